>>> hdl/sensor_report_quaternion_to_euler_unit_assert.svh
// assertion macros for the rotation report block
`ifndef SENSOR_REPORT_QUATERNION_TO_EULER_UNIT_ASSERT_SVH
`define SENSOR_REPORT_QUATERNION_TO_EULER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SRQE_ASSERT_IMPL(name, ante, cons) \
name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("implication check failed");
`define SRQE_ASSERT_NEXT(name, ante, cons) \
name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("next-cycle check failed");
`else
`define SRQE_ASSERT_IMPL(name, ante, cons)
`define SRQE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> hdl/srqe_pkg.sv
package srqe_pkg;

   localparam int MAX_PACKET_BYTES  = 128;
   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORD_STEPS = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
   localparam int ITER_W     = $clog2(CORD_STEPS);
   localparam int ATAN_IDX_W = 5;
   localparam int POS_W      = $clog2(MAX_PACKET_BYTES + 1);
   localparam int SQRT_STEPS = 29;
   localparam int CNT_W      = $clog2(SQRT_STEPS);

   localparam int MUL_W  = 30;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 33;
   localparam int XY_W   = 37;
   localparam int ANG_W  = 28;

   // csr indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_ID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;
   localparam int CSR_DATA_W = 15;

   // multiply operations, issued in this order
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_RJ = 4'd0;
   localparam logic [OP_W-1:0] OP_KI = 4'd1;
   localparam logic [OP_W-1:0] OP_RI = 4'd2;
   localparam logic [OP_W-1:0] OP_JK = 4'd3;
   localparam logic [OP_W-1:0] OP_II = 4'd4;
   localparam logic [OP_W-1:0] OP_JJ = 4'd5;
   localparam logic [OP_W-1:0] OP_KK = 4'd6;
   localparam logic [OP_W-1:0] OP_RK = 4'd7;
   localparam logic [OP_W-1:0] OP_IJ = 4'd8;
   localparam logic [OP_W-1:0] OP_SQ = 4'd9;

   // cordic jobs
   localparam int JOB_W = 2;
   localparam logic [JOB_W-1:0] JOB_PITCH = 2'd0;
   localparam logic [JOB_W-1:0] JOB_ROLL  = 2'd1;
   localparam logic [JOB_W-1:0] JOB_YAW   = 2'd2;
   localparam logic [JOB_W-1:0] JOB_SING  = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic signed [13:0] pitch_deg;
      logic signed [15:0] roll_deg;
      logic signed [15:0] yaw_deg;
      logic               fresh;
   } rsp_type;

   typedef struct packed {
      logic              clr;
      logic              mul_go;
      logic [OP_W-1:0]   mul_op;
      logic              sqrt_init;
      logic              sqrt_step;
      logic              cord_load;
      logic              cord_step;
      logic [ITER_W-1:0] cord_iter;
      logic [JOB_W-1:0]  job;
      logic              store;
      logic              fin;
   } cmd_type;

   typedef struct packed {
      logic singular;
   } stat_type;

   // atan(2^-n) in degrees, Q16
   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] n);
      logic signed [ANG_W-1:0] v;
      unique case (n)
         5'd0:  v = 28'sd2949120;
         5'd1:  v = 28'sd1740967;
         5'd2:  v = 28'sd919879;
         5'd3:  v = 28'sd466945;
         5'd4:  v = 28'sd234379;
         5'd5:  v = 28'sd117304;
         5'd6:  v = 28'sd58666;
         5'd7:  v = 28'sd29335;
         5'd8:  v = 28'sd14668;
         5'd9:  v = 28'sd7334;
         5'd10: v = 28'sd3667;
         5'd11: v = 28'sd1833;
         5'd12: v = 28'sd917;
         5'd13: v = 28'sd458;
         5'd14: v = 28'sd229;
         5'd15: v = 28'sd115;
         5'd16: v = 28'sd57;
         5'd17: v = 28'sd29;
         5'd18: v = 28'sd14;
         5'd19: v = 28'sd7;
         5'd20: v = 28'sd4;
         5'd21: v = 28'sd2;
         5'd22: v = 28'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/sensor_report_quaternion_to_euler_unit.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  srqe_pkg::req_type (rx_byte, last_byte)
// rsp       out        rsp_valid/rsp_stall  srqe_pkg::rsp_type (angles, fresh)
// csr       in         csr_write            csr_index, csr_wdata
//
// a byte is taken while req_stall is low; the byte that completes a report starts the
// conversion (ten multiplies, drain, decide, 29-step root, three cordic runs, finish)
// with req_stall high; a singular one skips the root and runs a single cordic job
// a last byte that completes a report holds req_stall until the new angles are loaded
// while a result item waits stalled in the output register the input stalls too
// reset is synchronous and clears parser, sequencer, held angles and the output valid flag
`include "sensor_report_quaternion_to_euler_unit_assert.svh"

module sensor_report_quaternion_to_euler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srqe_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output srqe_pkg::rsp_type                   rsp_item,
   input  logic                                csr_write,
   input  logic [srqe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srqe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic [7:0]  chan_ff, rid_ff;
   logic [14:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 8'd3;
         rid_ff  <= 8'd8;
         thr_ff  <= 15'd16368;
      end else if (csr_write) begin
         unique case (csr_index)
            srqe_pkg::CSR_CHANNEL:   chan_ff <= csr_wdata[7:0];
            srqe_pkg::CSR_REPORT_ID: rid_ff  <= csr_wdata[7:0];
            srqe_pkg::CSR_THRESHOLD: thr_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   logic accept, conv_start, conv_busy, conv_fin;
   logic [7:0][7:0] qbytes;
   srqe_pkg::cmd_type  cmd;
   srqe_pkg::stat_type stat;
   logic signed [13:0] held_pitch;
   logic signed [15:0] held_roll, held_yaw;

   // pend: last byte came with the report's final byte, wait for the angles
   logic pend_ff, pend_in, fin_q_ff, upd_ff, upd_in;
   logic rsp_valid_ff, rsp_valid_in, load_now, load_pend;
   srqe_pkg::rsp_type rsp_ff, rsp_in;

   assign req_stall = conv_busy | pend_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   srqe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_item),
      .channel   (chan_ff),
      .report_id (rid_ff),
      .start     (conv_start),
      .qbytes    (qbytes)
   );

   srqe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (conv_busy),
      .fin   (conv_fin)
   );

   srqe_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .qbytes     (qbytes),
      .threshold  (thr_ff),
      .stat       (stat),
      .held_pitch (held_pitch),
      .held_roll  (held_roll),
      .held_yaw   (held_yaw)
   );

   assign load_now  = accept & req_item.last_byte & ~conv_start;
   assign load_pend = fin_q_ff & pend_ff;

   always_comb begin
      pend_in = pend_ff;
      if (accept && req_item.last_byte && conv_start) pend_in = 1'b1;
      else if (load_pend) pend_in = 1'b0;

      upd_in = upd_ff;
      if (accept && req_item.last_byte) upd_in = 1'b0;
      else if (conv_start) upd_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (load_now || load_pend) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;

      rsp_in           = rsp_ff;
      rsp_in.pitch_deg = held_pitch;
      rsp_in.roll_deg  = held_roll;
      rsp_in.yaw_deg   = held_yaw;
      rsp_in.fresh     = load_pend | upd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         fin_q_ff     <= 1'b0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         fin_q_ff     <= conv_fin;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now || load_pend) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `SRQE_ASSERT_IMPL(a_pend_out_empty, pend_ff, !rsp_valid_ff)
   `SRQE_ASSERT_IMPL(a_start_idle, conv_start, !conv_busy && !pend_ff)
   `SRQE_ASSERT_NEXT(a_pend_delivers, load_pend, rsp_valid_ff && rsp_item.fresh)

endmodule

>>> hdl/srqe_parser.sv
module srqe_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  srqe_pkg::req_type item,
   input  logic [7:0]        channel,
   input  logic [7:0]        report_id,
   output logic              start,
   output logic [7:0][7:0]   qbytes
);

   localparam logic [2:0] PH_HEAD = 3'd0;
   localparam logic [2:0] PH_SCAN = 3'd1;
   localparam logic [2:0] PH_SKIP = 3'd2;
   localparam logic [2:0] PH_CAPT = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   localparam logic [7:0] TIMEBASE_ID = 8'hFB;
   localparam int CHANNEL_POS = 2;
   localparam int SCAN_POS    = 3;
   localparam int QUAT_FIRST  = 4;
   localparam int QUAT_LAST   = 11;
   localparam logic [2:0] SKIP_LEN = 3'd4;

   logic [srqe_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] skip_ff, skip_in, skip_dec;
   logic [3:0] cap_ff, cap_in, cap_nx, cap_off;
   logic       wr_en;

   assign cap_nx   = cap_ff + 4'd1;
   assign cap_off  = cap_nx - 4'(QUAT_FIRST);
   assign skip_dec = skip_ff - 3'd1;

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      cap_in   = cap_ff;
      start    = 1'b0;
      wr_en    = 1'b0;
      if (accept) begin
         if (pos_ff < srqe_pkg::POS_W'(srqe_pkg::MAX_PACKET_BYTES)) begin
            if (pos_ff == srqe_pkg::POS_W'(CHANNEL_POS)) begin
               if (item.rx_byte != channel) phase_in = PH_DONE;
            end else if (pos_ff == srqe_pkg::POS_W'(SCAN_POS)) begin
               if (phase_ff == PH_HEAD) phase_in = PH_SCAN;
            end else if (pos_ff > srqe_pkg::POS_W'(SCAN_POS)) begin
               unique case (phase_ff)
                  PH_SCAN: begin
                     if (item.rx_byte == TIMEBASE_ID) begin
                        skip_in  = SKIP_LEN;
                        phase_in = PH_SKIP;
                     end else if (item.rx_byte == report_id) begin
                        cap_in   = '0;
                        phase_in = PH_CAPT;
                     end
                  end
                  PH_SKIP: begin
                     skip_in = skip_dec;
                     if (skip_dec == '0) phase_in = PH_SCAN;
                  end
                  PH_CAPT: begin
                     cap_in = cap_nx;
                     if (cap_nx >= 4'(QUAT_FIRST) && cap_nx <= 4'(QUAT_LAST)) wr_en = 1'b1;
                     if (cap_nx == 4'(QUAT_LAST)) begin
                        start    = 1'b1;
                        phase_in = PH_DONE;
                     end
                  end
                  default: ;
               endcase
            end
            pos_in = pos_ff + 1'b1;
         end
         if (item.last_byte) begin
            pos_in   = '0;
            phase_in = PH_HEAD;
            skip_in  = '0;
            cap_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_HEAD;
         skip_ff  <= '0;
         cap_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         cap_ff   <= cap_in;
      end
   end

   // quaternion byte store, no reset
   always_ff @(posedge clock) begin
      if (wr_en) qbytes[cap_off[2:0]] <= item.rx_byte;
   end

endmodule

>>> hdl/srqe_ctrl.sv
module srqe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  srqe_pkg::stat_type stat,
   output srqe_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               fin
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_DRAIN  = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_SQRT   = 4'd4;
   localparam logic [3:0] ST_CLOAD  = 4'd5;
   localparam logic [3:0] ST_CITER  = 4'd6;
   localparam logic [3:0] ST_CSTORE = 4'd7;
   localparam logic [3:0] ST_FIN    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [srqe_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [srqe_pkg::JOB_W-1:0] job_ff, job_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.mul_op    = cnt_ff[srqe_pkg::OP_W-1:0];
      cmd.cord_iter = cnt_ff[srqe_pkg::ITER_W-1:0];
      cmd.job       = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.clr  = 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_go = 1'b1;
            if (cnt_ff[srqe_pkg::OP_W-1:0] == srqe_pkg::OP_SQ) state_in = ST_DRAIN;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: begin
            cnt_in = '0;
            if (stat.singular) begin
               job_in   = srqe_pkg::JOB_SING;
               state_in = ST_CLOAD;
            end else begin
               cmd.sqrt_init = 1'b1;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == srqe_pkg::CNT_W'(srqe_pkg::SQRT_STEPS - 1)) begin
               job_in   = srqe_pkg::JOB_PITCH;
               state_in = ST_CLOAD;
            end else cnt_in = cnt_ff + 1'b1;
         end
         ST_CLOAD: begin
            cmd.cord_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_CITER;
         end
         ST_CITER: begin
            cmd.cord_step = 1'b1;
            if (cnt_ff == srqe_pkg::CNT_W'(srqe_pkg::CORD_STEPS - 1)) state_in = ST_CSTORE;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_CSTORE: begin
            cmd.store = 1'b1;
            unique case (job_ff)
               srqe_pkg::JOB_PITCH: begin
                  job_in   = srqe_pkg::JOB_ROLL;
                  state_in = ST_CLOAD;
               end
               srqe_pkg::JOB_ROLL: begin
                  job_in   = srqe_pkg::JOB_YAW;
                  state_in = ST_CLOAD;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign fin  = (state_ff == ST_FIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         job_ff   <= srqe_pkg::JOB_PITCH;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         job_ff   <= job_in;
      end
   end

endmodule

>>> hdl/srqe_datapath.sv
module srqe_datapath (
   input  logic               clock,
   input  logic               reset,
   input  srqe_pkg::cmd_type  cmd,
   input  logic [7:0][7:0]    qbytes,
   input  logic [14:0]        threshold,
   output srqe_pkg::stat_type stat,
   output logic signed [13:0] held_pitch,
   output logic signed [15:0] held_roll,
   output logic signed [15:0] held_yaw
);

   localparam int MW = srqe_pkg::MUL_W;
   localparam int AW = srqe_pkg::ACC_W;
   localparam int XW = srqe_pkg::XY_W;
   localparam int GW = srqe_pkg::ANG_W;

   localparam logic signed [GW-1:0] DEG90  = GW'(90 * 65536);
   localparam logic signed [GW-1:0] DEG180 = GW'(180 * 65536);
   localparam logic signed [XW-1:0] ONE_Q28 = XW'(64'sd1 << 28);
   localparam logic signed [AW:0]   ONE_S   = (AW + 1)'(64'sd1 << 28);
   localparam logic [56:0]          ONE_Q56 = 57'd1 << 56;

   logic signed [15:0] qi, qj, qk, qr;
   assign qi = $signed({qbytes[1], qbytes[0]});
   assign qj = $signed({qbytes[3], qbytes[2]});
   assign qk = $signed({qbytes[5], qbytes[4]});
   assign qr = $signed({qbytes[7], qbytes[6]});

   // multiplier, one product per cycle, accumulated in the cycle after it is formed
   logic signed [MW-1:0] op_a, op_b, sc;
   logic signed [srqe_pkg::PROD_W-1:0] prod_ff;
   logic [srqe_pkg::OP_W-1:0] pop_ff;
   logic pv_ff;

   always_comb begin
      unique case (cmd.mul_op)
         srqe_pkg::OP_RJ: begin op_a = MW'(qr); op_b = MW'(qj); end
         srqe_pkg::OP_KI: begin op_a = MW'(qk); op_b = MW'(qi); end
         srqe_pkg::OP_RI: begin op_a = MW'(qr); op_b = MW'(qi); end
         srqe_pkg::OP_JK: begin op_a = MW'(qj); op_b = MW'(qk); end
         srqe_pkg::OP_II: begin op_a = MW'(qi); op_b = MW'(qi); end
         srqe_pkg::OP_JJ: begin op_a = MW'(qj); op_b = MW'(qj); end
         srqe_pkg::OP_KK: begin op_a = MW'(qk); op_b = MW'(qk); end
         srqe_pkg::OP_RK: begin op_a = MW'(qr); op_b = MW'(qk); end
         srqe_pkg::OP_IJ: begin op_a = MW'(qi); op_b = MW'(qj); end
         srqe_pkg::OP_SQ: begin op_a = sc;      op_b = sc;      end
         default:         begin op_a = '0;      op_b = '0;      end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      pop_ff  <= cmd.mul_op;
   end

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= cmd.mul_go;
   end

   logic signed [AW-1:0] s_ff, ry_ff, rx_ff, yy_ff, yx_ff, p33;
   logic [56:0] sq_ff;
   assign p33 = prod_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         s_ff  <= '0;
         ry_ff <= '0;
         rx_ff <= '0;
         yy_ff <= '0;
         yx_ff <= '0;
      end else if (pv_ff) begin
         unique case (pop_ff)
            srqe_pkg::OP_RJ: s_ff  <= s_ff + p33;
            srqe_pkg::OP_KI: s_ff  <= s_ff - p33;
            srqe_pkg::OP_RI: ry_ff <= ry_ff + p33;
            srqe_pkg::OP_JK: ry_ff <= ry_ff + p33;
            srqe_pkg::OP_II: rx_ff <= rx_ff + p33;
            srqe_pkg::OP_JJ: begin
               rx_ff <= rx_ff + p33;
               yx_ff <= yx_ff + p33;
            end
            srqe_pkg::OP_KK: yx_ff <= yx_ff + p33;
            srqe_pkg::OP_RK: yy_ff <= yy_ff + p33;
            srqe_pkg::OP_IJ: yy_ff <= yy_ff + p33;
            srqe_pkg::OP_SQ: sq_ff <= prod_ff[56:0];
            default: ;
         endcase
      end
   end

   // sin pitch term, singularity test and clamp
   logic signed [AW:0] s_full, s_mag;
   assign s_full = {s_ff, 1'b0};
   assign s_mag  = s_full[AW] ? -s_full : s_full;
   assign stat.singular = (s_mag >= (AW + 1)'({threshold, 14'd0}));

   always_comb begin
      if (s_full > ONE_S) sc = MW'(ONE_S);
      else if (s_full < -ONE_S) sc = MW'(-ONE_S);
      else sc = MW'(s_full);
   end

   // square root, two radicand bits per step
   logic [57:0] rad_ff;
   logic [31:0] rem_ff, rem_sh, trial;
   logic [28:0] root_ff;
   assign rem_sh = {rem_ff[29:0], rad_ff[57:56]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rad_ff  <= {1'b0, ONE_Q56 - sq_ff};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[55:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[27:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[27:0], 1'b0};
         end
      end
   end

   // cordic vectoring unit
   logic signed [XW-1:0] x_ff, y_ff, x0, y0, dx, dy;
   logic signed [GW-1:0] z_ff, z_res, atan_v;
   logic zero_ff;

   always_comb begin
      unique case (cmd.job)
         srqe_pkg::JOB_PITCH: begin
            y0 = XW'(sc);
            x0 = XW'({1'b0, root_ff});
         end
         srqe_pkg::JOB_ROLL: begin
            y0 = XW'($signed({ry_ff, 1'b0}));
            x0 = ONE_Q28 - XW'({rx_ff, 1'b0});
         end
         srqe_pkg::JOB_YAW: begin
            y0 = XW'($signed({yy_ff, 1'b0}));
            x0 = ONE_Q28 - XW'({yx_ff, 1'b0});
         end
         default: begin
            y0 = XW'($signed({qi, 14'd0}));
            x0 = XW'($signed({qr, 14'd0}));
         end
      endcase
   end

   assign dx     = y_ff >>> cmd.cord_iter;
   assign dy     = x_ff >>> cmd.cord_iter;
   assign atan_v = srqe_pkg::atan_q16(srqe_pkg::ATAN_IDX_W'(cmd.cord_iter));
   assign z_res  = zero_ff ? '0 : z_ff;

   always_ff @(posedge clock) begin
      if (cmd.cord_load) begin
         zero_ff <= (x0 == '0) && (y0 == '0);
         if (x0[XW-1]) begin
            x_ff <= -x0;
            y_ff <= -y0;
            z_ff <= y0[XW-1] ? -DEG180 : DEG180;
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (cmd.cord_step) begin
         if (!y_ff[XW-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_v;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_v;
         end
      end
   end

   logic signed [GW-1:0] pz_ff, rz_ff, yz_ff;
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         unique case (cmd.job)
            srqe_pkg::JOB_PITCH: pz_ff <= z_res;
            srqe_pkg::JOB_ROLL:  rz_ff <= z_res;
            srqe_pkg::JOB_YAW:   yz_ff <= z_res;
            default: begin
               yz_ff <= {z_res[GW-2:0], 1'b0};
               pz_ff <= s_full[AW] ? -DEG90 : DEG90;
               rz_ff <= '0;
            end
         endcase
      end
   end

   // round to 1/64 degree
   logic signed [GW-1:0] p_rnd, r_rnd, y_rnd;
   assign p_rnd = (pz_ff + GW'(512)) >>> 10;
   assign r_rnd = (DEG90 - rz_ff + GW'(512)) >>> 10;
   assign y_rnd = (yz_ff - DEG90 + GW'(512)) >>> 10;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_pitch <= '0;
         held_roll  <= '0;
         held_yaw   <= '0;
      end else if (cmd.fin) begin
         held_pitch <= p_rnd[13:0];
         held_roll  <= r_rnd[15:0];
         held_yaw   <= y_rnd[15:0];
      end
   end

endmodule
